// ----- design/sphd_pkg.sv -----
package sphd_pkg;

    // word and block geometry
    localparam int WORD_W     = 64;
    localparam int LANE_W     = 32;
    localparam int LANE_CNT   = 16;
    localparam int STATE_W    = LANE_W * LANE_CNT;
    localparam int RATE_BYTES = 32;
    localparam int RATE_W     = 8 * RATE_BYTES;
    localparam int TAIL_W     = 5;
    localparam int PAD_W      = 8;

    // end-of-block marker XORed into the top rate byte of a final block
    localparam logic [7:0] END_MARK = 8'h01;

    typedef logic [LANE_W-1:0]  t_lane;
    typedef t_lane [LANE_CNT-1:0] t_lanes;
    typedef logic [RATE_W-1:0]  t_rate;

endpackage

// ----- design/sphd_if.sv -----
// message block channel
interface sphd_blk_if;
    logic                         valid;
    logic                         ready;
    logic [sphd_pkg::WORD_W-1:0]  block_word0;
    logic [sphd_pkg::WORD_W-1:0]  block_word1;
    logic [sphd_pkg::WORD_W-1:0]  block_word2;
    logic [sphd_pkg::WORD_W-1:0]  block_word3;
    logic [sphd_pkg::TAIL_W-1:0]  tail_bytes;
    logic                         last;

    modport source (
        output valid, block_word0, block_word1, block_word2, block_word3,
               tail_bytes, last,
        input  ready
    );
    modport sink (
        input  valid, block_word0, block_word1, block_word2, block_word3,
               tail_bytes, last,
        output ready
    );
endinterface

// digest channel
interface sphd_dig_if;
    logic                         valid;
    logic                         ready;
    logic [sphd_pkg::WORD_W-1:0]  digest_word0;
    logic [sphd_pkg::WORD_W-1:0]  digest_word1;
    logic [sphd_pkg::WORD_W-1:0]  digest_word2;
    logic [sphd_pkg::WORD_W-1:0]  digest_word3;

    modport source (
        output valid, digest_word0, digest_word1, digest_word2, digest_word3,
        input  ready
    );
    modport sink (
        input  valid, digest_word0, digest_word1, digest_word2, digest_word3,
        output ready
    );
endinterface

// pad byte register write channel
interface sphd_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [sphd_pkg::PAD_W-1:0]  pad_byte;

    modport source (output valid, pad_byte, input ready);
    modport sink   (input valid, pad_byte, output ready);
endinterface

// ----- design/sphd_perm.sv -----
module sphd_perm (
    input  sphd_pkg::t_lanes i_lanes,
    output sphd_pkg::t_lanes o_lanes
);

    localparam sphd_pkg::t_lane RC [0:7] = '{
        32'h243F6A88, 32'h85A308D3, 32'h13198A2E, 32'h03707344,
        32'hA4093822, 32'h299F31D0, 32'h082EFA98, 32'hEC4E6C89
    };

    function automatic sphd_pkg::t_lane rotr(sphd_pkg::t_lane x, int unsigned n);
        return (x >> n) | (x << (sphd_pkg::LANE_W - n));
    endfunction

    // one half-round over the four columns (a, b, c, d rows of four lanes)
    function automatic sphd_pkg::t_lanes half_round(sphd_pkg::t_lanes x,
                                                    int unsigned ra, int unsigned rb);
        sphd_pkg::t_lanes y;
        y = x;
        for (int i = 0; i < 4; i++) begin
            y[8+i]  = y[8+i]  ^ rotr(y[i], ra);
            y[12+i] = y[12+i] ^ rotr(y[4+i], rb);
            y[i]    = y[i]    ^ ((y[4+i] & y[8+i]) ^ y[12+i]);
            y[4+i]  = y[4+i]  ^ ((y[i] & y[12+i]) ^ y[8+i]);
        end
        return y;
    endfunction

    // rotate rows b, c, d left by sb, sc, sd lanes
    function automatic sphd_pkg::t_lanes rotate_rows(sphd_pkg::t_lanes x,
                                                     int unsigned sb, int unsigned sc,
                                                     int unsigned sd);
        sphd_pkg::t_lanes y;
        y = x;
        for (int i = 0; i < 4; i++) begin
            y[4+i]  = x[4  + ((i + sb) & 3)];
            y[8+i]  = x[8  + ((i + sc) & 3)];
            y[12+i] = x[12 + ((i + sd) & 3)];
        end
        return y;
    endfunction

    sphd_pkg::t_lanes w_stage [0:4];

    assign w_stage[0] = i_lanes;

    // four rounds: column half-round, shuffle, diagonal half-round, unshuffle
    for (genvar r = 0; r < 4; r++) begin : g_round
        sphd_pkg::t_lanes w_col_in;
        sphd_pkg::t_lanes w_col;
        sphd_pkg::t_lanes w_diag_in;

        always_comb begin
            w_col_in    = w_stage[r];
            w_col_in[0] = w_col_in[0] ^ RC[2*r];
        end

        assign w_col = rotate_rows(half_round(w_col_in, 24, 9), 1, 2, 3);

        always_comb begin
            w_diag_in    = w_col;
            w_diag_in[0] = w_diag_in[0] ^ RC[2*r+1];
        end

        assign w_stage[r+1] = rotate_rows(half_round(w_diag_in, 7, 16), 3, 2, 1);
    end

    assign o_lanes = w_stage[4];

endmodule

// ----- design/sponge_hash_256bit_digest_unit.sv -----
// A block word accepted into the input register is absorbed into the sponge state from
// there; for a final word the digest is registered in the digest output register as the
// word is absorbed, so o_dig.valid rises with the absorb.
// Throughput: one block word per cycle; a final word waits only while the previous
// digest is held by o_dig back-pressure. The eight half-rounds are combinational.
// Reset (i_rst_n low, synchronous) clears the sponge state, the pad byte and all valids.
module sponge_hash_256bit_digest_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sphd_blk_if.sink   i_blk,
    sphd_cfg_if.sink   i_cfg,
    sphd_dig_if.source o_dig
);

    logic                        r_in_valid;
    sphd_pkg::t_rate             r_in_blk;
    logic [sphd_pkg::TAIL_W-1:0] r_in_tail;
    logic                        r_in_last;

    logic [sphd_pkg::PAD_W-1:0]  r_pad;
    sphd_pkg::t_lanes            r_state;
    sphd_pkg::t_lanes            n_state;

    logic                        r_out_valid;
    sphd_pkg::t_rate             r_dig;

    sphd_pkg::t_rate             w_mix;
    sphd_pkg::t_lanes            w_absorb;
    sphd_pkg::t_lanes            w_perm;
    logic                        w_adv;
    logic                        w_load_out;

    // held word moves on unless it is final and the digest slot stays full
    assign w_adv      = r_in_valid && !(r_in_last && r_out_valid && !o_dig.ready);
    assign w_load_out = w_adv && r_in_last;
    assign i_blk.ready = !r_in_valid || w_adv;
    assign i_cfg.ready = 1'b1;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_blk.ready) begin
            r_in_valid <= i_blk.valid;
        end
        if (i_blk.valid && i_blk.ready) begin
            r_in_blk  <= {i_blk.block_word3, i_blk.block_word2,
                          i_blk.block_word1, i_blk.block_word0};
            r_in_tail <= i_blk.tail_bytes;
            r_in_last <= i_blk.last;
        end
    end

    // pad byte register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pad <= '0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_pad <= i_cfg.pad_byte;
        end
    end

    // final block: keep tail bytes, add pad at tail position and end marker
    always_comb begin
        w_mix = r_in_blk;
        if (r_in_last) begin
            for (int b = 0; b < sphd_pkg::RATE_BYTES; b++) begin
                if (sphd_pkg::TAIL_W'(b) >= r_in_tail) begin
                    w_mix[8*b +: 8] = '0;
                end
                if (sphd_pkg::TAIL_W'(b) == r_in_tail) begin
                    w_mix[8*b +: 8] = w_mix[8*b +: 8] ^ r_pad;
                end
            end
            w_mix[sphd_pkg::RATE_W-1 -: 8] = w_mix[sphd_pkg::RATE_W-1 -: 8]
                                             ^ sphd_pkg::END_MARK;
        end
    end

    assign w_absorb = r_state ^ sphd_pkg::t_lanes'(
                          {{(sphd_pkg::STATE_W - sphd_pkg::RATE_W){1'b0}}, w_mix});

    sphd_perm u_perm (
        .i_lanes (w_absorb),
        .o_lanes (w_perm)
    );

    // state update: cleared after a digest
    always_comb begin
        n_state = r_state;
        if (w_adv) begin
            n_state = r_in_last ? '0 : w_perm;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else begin
            r_state <= n_state;
        end
    end

    // digest output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_dig.ready) begin
            r_out_valid <= 1'b0;
        end
        if (w_load_out) begin
            r_dig <= sphd_pkg::t_rate'(w_perm);
        end
    end

    assign o_dig.valid        = r_out_valid;
    assign o_dig.digest_word0 = r_dig[0*sphd_pkg::WORD_W +: sphd_pkg::WORD_W];
    assign o_dig.digest_word1 = r_dig[1*sphd_pkg::WORD_W +: sphd_pkg::WORD_W];
    assign o_dig.digest_word2 = r_dig[2*sphd_pkg::WORD_W +: sphd_pkg::WORD_W];
    assign o_dig.digest_word3 = r_dig[3*sphd_pkg::WORD_W +: sphd_pkg::WORD_W];

    // state is clear after a final word is absorbed
    a_clear_after_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load_out |=> (r_state == '0))
        else $error("sponge state not cleared after final word");

    // a stalled digest is neither dropped nor overwritten
    a_digest_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_dig.ready) |=> (r_out_valid && $stable(r_dig)))
        else $error("stalled digest changed");

    // a held input word that cannot advance stays put
    a_input_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_adv) |=> (r_in_valid && $stable(r_in_blk) && $stable(r_in_last)))
        else $error("blocked input word lost");

    // state only changes when a word is absorbed
    a_state_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(r_state))
        else $error("sponge state changed without a word");

endmodule

// ----- dv/tb_sponge_hash_256bit_digest_unit.sv -----
module tb_sponge_hash_256bit_digest_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES = 6;     // lets the input and digest registers empty
    localparam int HOLD_CYCLES   = 400;   // long digest back-pressure stretch
    localparam int QUIET_LIMIT   = 3000;  // cycles without any handshake before giving up
    localparam int PHASE_WORDS   = 110;

    localparam sphd_pkg::t_lane ROUND_K [8] = '{
        32'h243F6A88, 32'h85A308D3, 32'h13198A2E, 32'h03707344,
        32'hA4093822, 32'h299F31D0, 32'h082EFA98, 32'hEC4E6C89
    };

    typedef struct packed {
        sphd_pkg::t_rate             data;
        logic [sphd_pkg::TAIL_W-1:0] tail;
        logic                        last;
    } t_blk_word;

    logic i_clk;
    logic i_rst_n;

    sphd_blk_if blk_if ();
    sphd_dig_if dig_if ();
    sphd_cfg_if cfg_if ();

    sponge_hash_256bit_digest_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_blk   (blk_if),
        .i_cfg   (cfg_if),
        .o_dig   (dig_if)
    );

    // words waiting to be offered, digests waiting to come out
    t_blk_word       word_q[$];
    sphd_pkg::t_rate digest_q[$];

    // shadow of the sponge
    sphd_pkg::t_lanes           sponge_model;
    logic [sphd_pkg::PAD_W-1:0] pad_model;

    t_blk_word cur_word;
    int  src_idle_pct;
    int  snk_idle_pct;
    bit  hold_req;
    bit  hold_done;
    int  hold_left;
    int  words_accepted;
    int  digests_checked;
    int  pad_writes;
    int  errors;
    int  quiet_cycles;
    logic [31:0] tails_seen;

    // clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic sphd_pkg::t_lane rotr(input sphd_pkg::t_lane x, input int n);
        return (x >> n) | (x << (sphd_pkg::LANE_W - n));
    endfunction

    function automatic bit roll_idle(input int pct);
        return $urandom_range(99) < pct;
    endfunction

    // rows: a = lanes 0..3, b = 4..7, c = 8..11, d = 12..15
    function automatic sphd_pkg::t_lanes half_round(input sphd_pkg::t_lanes s,
                                                    input int ra, input int rb);
        for (int i = 0; i < 4; i++) begin
            s[8+i]  ^= rotr(s[i], ra);
            s[12+i] ^= rotr(s[4+i], rb);
            s[i]    ^= (s[4+i] & s[8+i]) ^ s[12+i];
            s[4+i]  ^= (s[i] & s[12+i]) ^ s[8+i];
        end
        return s;
    endfunction

    function automatic sphd_pkg::t_lanes shift_rows(input sphd_pkg::t_lanes s,
                                                    input int sb, input int sc,
                                                    input int sd);
        sphd_pkg::t_lanes t;
        t = s;
        for (int i = 0; i < 4; i++) begin
            t[4+i]  = s[4 + ((i + sb) & 3)];
            t[8+i]  = s[8 + ((i + sc) & 3)];
            t[12+i] = s[12 + ((i + sd) & 3)];
        end
        return t;
    endfunction

    function automatic sphd_pkg::t_lanes sponge_permute(input sphd_pkg::t_lanes s);
        for (int r = 0; r < 8; r += 2) begin
            s[0] ^= ROUND_K[r];
            s = half_round(s, 24, 9);
            s = shift_rows(s, 1, 2, 3);
            s[0] ^= ROUND_K[r+1];
            s = half_round(s, 7, 16);
            s = shift_rows(s, 3, 2, 1);
        end
        return s;
    endfunction

    // absorb one accepted word; a final word yields the expected digest
    task automatic absorb_word(input t_blk_word w);
        sphd_pkg::t_rate rate_part;
        sphd_pkg::t_rate keep;
        begin
            rate_part = sponge_model[sphd_pkg::RATE_W/sphd_pkg::LANE_W-1:0];
            if (!w.last) begin
                rate_part ^= w.data;
            end else begin
                keep = (sphd_pkg::t_rate'(1) << (8 * w.tail)) - sphd_pkg::t_rate'(1);
                rate_part ^= w.data & keep;
                rate_part ^= sphd_pkg::t_rate'(pad_model) << (8 * w.tail);
                rate_part[sphd_pkg::RATE_W-1 -: 8] ^= sphd_pkg::END_MARK;
                tails_seen[w.tail] = 1'b1;
            end
            sponge_model[sphd_pkg::RATE_W/sphd_pkg::LANE_W-1:0] = rate_part;
            sponge_model = sponge_permute(sponge_model);
            if (w.last) begin
                digest_q.push_back(sponge_model[sphd_pkg::RATE_W/sphd_pkg::LANE_W-1:0]);
                sponge_model = '0;
            end
        end
    endtask

    // block word driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            blk_if.valid <= 1'b0;
        end else begin
            if (blk_if.valid && blk_if.ready) begin
                absorb_word(cur_word);
                words_accepted++;
            end
            if (!blk_if.valid || blk_if.ready) begin
                if (word_q.size() != 0 && !roll_idle(src_idle_pct)) begin
                    cur_word = word_q.pop_front();
                    blk_if.valid       <= 1'b1;
                    blk_if.block_word0 <= cur_word.data[63:0];
                    blk_if.block_word1 <= cur_word.data[127:64];
                    blk_if.block_word2 <= cur_word.data[191:128];
                    blk_if.block_word3 <= cur_word.data[255:192];
                    blk_if.tail_bytes  <= cur_word.tail;
                    blk_if.last        <= cur_word.last;
                end else begin
                    blk_if.valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_digest();
        sphd_pkg::t_rate want;
        logic [sphd_pkg::WORD_W-1:0] got [4];
        begin
            got[0] = dig_if.digest_word0;
            got[1] = dig_if.digest_word1;
            got[2] = dig_if.digest_word2;
            got[3] = dig_if.digest_word3;
            if (digest_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected digest %h %h %h %h", $time,
                         got[3], got[2], got[1], got[0]);
            end else begin
                want = digest_q.pop_front();
                digests_checked++;
                for (int k = 0; k < 4; k++) begin
                    if (got[k] !== want[64*k +: 64]) begin
                        errors++;
                        $display("%0t: digest_word%0d expected %h actual %h", $time, k,
                                 want[64*k +: 64], got[k]);
                    end
                end
            end
        end
    endtask

    // digest monitor, with one long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            dig_if.ready <= 1'b0;
            hold_left    <= 0;
        end else begin
            if (dig_if.valid && dig_if.ready)
                check_digest();
            if (hold_req && !hold_done) begin
                hold_done    <= 1'b1;
                hold_left    <= HOLD_CYCLES;
                dig_if.ready <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left    <= hold_left - 1;
                dig_if.ready <= 1'b0;
            end else begin
                dig_if.ready <= !roll_idle(snk_idle_pct);
            end
        end
    end

    // watchdog: no handshake of any kind for too long
    always @(posedge i_clk) begin
        if ((blk_if.valid && blk_if.ready) || (dig_if.valid && dig_if.ready) ||
            (cfg_if.valid && cfg_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: timeout, %0d digests still pending", $time, digest_q.size());
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [sphd_pkg::WORD_W-1:0] rand_word64();
        int r;
        r = $urandom_range(7);
        if (r == 0) return '1;
        if (r == 1) return '0;
        return {$urandom, $urandom};
    endfunction

    function automatic sphd_pkg::t_rate rand_block();
        return {rand_word64(), rand_word64(), rand_word64(), rand_word64()};
    endfunction

    task automatic push_word(input sphd_pkg::t_rate data, input int tail, input bit last);
        t_blk_word w;
        begin
            w.data = data;
            w.tail = tail[sphd_pkg::TAIL_W-1:0];
            w.last = last;
            word_q.push_back(w);
        end
    endtask

    // one message: body words with noise in the ignored tail field, then a final word
    task automatic push_message(output int n_words);
        int n_body;
        int r;
        int tail;
        begin
            r = $urandom_range(99);
            if (r < 60)      n_body = $urandom_range(2);
            else if (r < 90) n_body = $urandom_range(6, 3);
            else             n_body = $urandom_range(16, 7);
            for (int i = 0; i < n_body; i++)
                push_word(rand_block(), $urandom_range(31), 1'b0);
            r = $urandom_range(99);
            if (r < 15)      tail = 0;
            else if (r < 30) tail = 31;
            else             tail = $urandom_range(31);
            push_word(rand_block(), tail, 1'b1);
            n_words = n_body + 1;
        end
    endtask

    // wait until every word is in and every digest is out, then let the pipe empty
    task automatic wait_drained();
        begin
            @(negedge i_clk);
            while (word_q.size() != 0 || blk_if.valid || digest_q.size() != 0)
                @(negedge i_clk);
            repeat (SETTLE_CYCLES) @(negedge i_clk);
        end
    endtask

    task automatic write_pad(input logic [sphd_pkg::PAD_W-1:0] v);
        begin
            @(posedge i_clk);
            cfg_if.valid    <= 1'b1;
            cfg_if.pad_byte <= v;
            @(posedge i_clk);
            while (!cfg_if.ready) @(posedge i_clk);
            pad_model = v;
            pad_writes++;
            cfg_if.valid <= 1'b0;
        end
    endtask

    // stimulus sequencing
    initial begin
        logic [sphd_pkg::PAD_W-1:0] phase_pad [5];
        int n;
        int filled;
        int base;

        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        blk_if.valid   = 1'b0;
        blk_if.block_word0 = '0;
        blk_if.block_word1 = '0;
        blk_if.block_word2 = '0;
        blk_if.block_word3 = '0;
        blk_if.tail_bytes  = '0;
        blk_if.last        = 1'b0;
        dig_if.ready   = 1'b0;
        cfg_if.valid   = 1'b0;
        cfg_if.pad_byte = '0;
        sponge_model   = '0;
        pad_model      = '0;
        tails_seen     = '0;
        src_idle_pct   = 19;
        snk_idle_pct   = 19;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed, pad at its reset value
        push_word('0, 0, 1'b1);                        // empty message
        push_word('1, 31, 1'b1);                       // longest tail
        push_word('1, 1, 1'b1);                        // one byte, rest ignored
        push_word('1, 31, 1'b0);                       // tail ignored on a body word
        push_word('1, 0, 1'b1);                        // message end with no tail bytes
        push_word('0, 5, 1'b0);
        push_word(rand_block(), 12, 1'b0);
        push_word({4{64'hFFFF_FFFF_FFFF_FFFF}}, 8, 1'b1);   // word boundary
        push_word(rand_block(), 7, 1'b1);
        push_word(rand_block(), 24, 1'b1);
        push_word(rand_block(), 16, 1'b1);
        push_word(rand_block(), 0, 1'b0);
        push_word('1, 30, 1'b1);
        wait_drained();

        // directed, top pad value
        write_pad(8'hFF);
        push_word('0, 0, 1'b1);
        push_word('1, 31, 1'b1);
        push_word(rand_block(), 0, 1'b0);
        push_word(rand_block(), 23, 1'b1);
        push_word('1, 15, 1'b1);
        wait_drained();

        // random phases over several pad settings
        phase_pad[0] = 8'h00;
        phase_pad[1] = 8'(($urandom_range(254, 1)));
        phase_pad[2] = 8'hFF;
        phase_pad[3] = 8'h80;
        phase_pad[4] = 8'(($urandom_range(255)));
        for (int p = 0; p < 5; p++) begin
            write_pad(phase_pad[p]);
            // one phase runs with no idling on either side
            src_idle_pct = (p == 2) ? 0 : 19;
            snk_idle_pct = (p == 2) ? 0 : 19;
            base   = words_accepted;
            filled = 0;
            while (filled < PHASE_WORDS) begin
                push_message(n);
                filled += n;
            end
            // stall the digest side long enough to back up the input
            if (p == 0) begin
                @(negedge i_clk);
                while (words_accepted < base + 20) @(negedge i_clk);
                hold_req = 1'b1;
            end
            wait_drained();
        end

        $display("covered %0d block words, %0d digests checked, %0d pad writes",
                 words_accepted, digests_checked, pad_writes);
        $display("final blocks hit %0d of 32 tail lengths; %0d mismatches",
                 $countones(tails_seen), errors);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
